// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

  // Field and register widths
  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int NUM_COEF   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int TEMP_OUT_W = 15;
  localparam int PRES_OUT_W = 17;

  // Internal datapath widths
  localparam int REF_SHIFT = 8;                      // C5 is used as C5 * 256
  localparam int DT_W      = RAW_W + 1;              // signed dT
  localparam int PROD_W    = DT_W + COEF_W + 1;      // dT times a coefficient
  localparam int SQ_W      = 2 * DT_W;               // dT squared
  localparam int T_W       = 21;                     // temperature and its offsets
  localparam int TSQ_W     = 2 * T_W;                // squared temperature offsets
  localparam int OFF_W     = 40;
  localparam int SENS_W    = 40;
  localparam int SPLIT_W   = 20;                     // low slice of SENS in the split product
  localparam int LO_W      = RAW_W + SPLIT_W;
  localparam int HI_W      = RAW_W + 1 + SENS_W - SPLIT_W;
  localparam int FULL_W    = RAW_W + 1 + SENS_W;

  // Shift amounts of the compensation scheme
  localparam int T_SHIFT         = 23;
  localparam int OFF_SHIFT       = 7;
  localparam int SENS_SHIFT      = 8;
  localparam int T2_SHIFT        = 31;
  localparam int MUL_SHIFT       = 21;
  localparam int P_SHIFT         = 15;
  localparam int OFF_BASE_SHIFT  = 16;
  localparam int SENS_BASE_SHIFT = 15;

  // Temperature thresholds and output limits
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int TEMP_LOW  = -4000;
  localparam int TEMP_HIGH = 8500;
  localparam int PRES_HIGH = 131071;

  // Coefficient reset values
  localparam logic [COEF_W-1:0] RST_C1 = 16'd40127;
  localparam logic [COEF_W-1:0] RST_C2 = 16'd36924;
  localparam logic [COEF_W-1:0] RST_C3 = 16'd23317;
  localparam logic [COEF_W-1:0] RST_C4 = 16'd23282;
  localparam logic [COEF_W-1:0] RST_C5 = 16'd33464;
  localparam logic [COEF_W-1:0] RST_C6 = 16'd28312;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS_BASE   = 3'd0,
    CFG_OFFSET_BASE = 3'd1,
    CFG_SENS_TEMP   = 3'd2,
    CFG_OFFSET_TEMP = 3'd3,
    CFG_REF_TEMP    = 3'd4,
    CFG_TEMP_SLOPE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } cal_t;

  // First-order results with the terms needed for the second-order step
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic                     rv;
    logic signed [T_W-1:0]    temp;
    logic signed [T_W-1:0]    a;     // temp - 2000
    logic signed [T_W-1:0]    b;     // temp + 1500
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [T_W-1:0]           t2;
  } fo_t;

  // Fully corrected terms
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic                     rv;
    logic signed [T_W-1:0]    temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } so_t;

  function automatic logic coef_ok(input logic [COEF_W-1:0] c);
    return (c != '0) && (c != '1);
  endfunction

endpackage

// ===== rtl/bpc_if.sv =====
`timescale 1ns / 1ps

// Raw conversion pair channel
interface bpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
  logic [bpc_pkg::RAW_W-1:0]  raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

// Compensated result channel
interface bpc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bpc_pkg::TEMP_OUT_W-1:0]  temperature_centi;
  logic [bpc_pkg::PRES_OUT_W-1:0]         pressure_centi_mbar;
  logic                                   reading_valid;
  logic                                   calibration_valid;

  modport source (output valid, temperature_centi, pressure_centi_mbar, reading_valid,
                  calibration_valid, input ready);
  modport sink   (input valid, temperature_centi, pressure_centi_mbar, reading_valid,
                  calibration_valid, output ready);
endinterface

// ===== rtl/bpc_cfg_regs.sv =====
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]       cfg_data,
  output bpc_pkg::cal_t                    cal,
  output logic                             cal_ok
);

  // Coefficient registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.c1 <= bpc_pkg::RST_C1;
      cal.c2 <= bpc_pkg::RST_C2;
      cal.c3 <= bpc_pkg::RST_C3;
      cal.c4 <= bpc_pkg::RST_C4;
      cal.c5 <= bpc_pkg::RST_C5;
      cal.c6 <= bpc_pkg::RST_C6;
    end else if (cfg_we) begin
      case (bpc_pkg::cfg_idx_t'(cfg_index))
        bpc_pkg::CFG_SENS_BASE:   cal.c1 <= cfg_data;
        bpc_pkg::CFG_OFFSET_BASE: cal.c2 <= cfg_data;
        bpc_pkg::CFG_SENS_TEMP:   cal.c3 <= cfg_data;
        bpc_pkg::CFG_OFFSET_TEMP: cal.c4 <= cfg_data;
        bpc_pkg::CFG_REF_TEMP:    cal.c5 <= cfg_data;
        bpc_pkg::CFG_TEMP_SLOPE:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stuck-at-zero or all-ones words mark a bad calibration
  assign cal_ok = bpc_pkg::coef_ok(cal.c1) && bpc_pkg::coef_ok(cal.c2) &&
                  bpc_pkg::coef_ok(cal.c3) && bpc_pkg::coef_ok(cal.c4) &&
                  bpc_pkg::coef_ok(cal.c5) && bpc_pkg::coef_ok(cal.c6);

endmodule

// ===== rtl/bpc_first_order.sv =====
`timescale 1ns / 1ps

module bpc_first_order (
  input  logic                          clk,
  input  logic                          rst,
  input  bpc_pkg::cal_t                 cal,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output bpc_pkg::fo_t                  dn_data
);

  logic v1, v2;
  logic en1, en2, en3;

  logic [bpc_pkg::RAW_W-1:0]          s1_d1;
  logic                               s1_rv;
  logic signed [bpc_pkg::DT_W-1:0]    s1_dt;
  logic signed [bpc_pkg::DT_W-1:0]    dt_next;

  logic [bpc_pkg::RAW_W-1:0]          s2_d1;
  logic                               s2_rv;
  logic signed [bpc_pkg::PROD_W-1:0]  s2_pt;
  logic signed [bpc_pkg::PROD_W-1:0]  s2_poff;
  logic signed [bpc_pkg::PROD_W-1:0]  s2_psens;
  logic signed [bpc_pkg::SQ_W-1:0]    s2_psq;

  logic signed [bpc_pkg::T_W-1:0]     a_c;
  logic signed [bpc_pkg::OFF_W-1:0]   off_base;
  logic signed [bpc_pkg::SENS_W-1:0]  sens_base;

  // Stage enables: a stage loads when empty or when it drains downstream
  assign en3      = !dn_valid || dn_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) dn_valid <= v2;
    end
  end

  // Stage 1: dT = D2 - C5 * 256
  assign dt_next = $signed({1'b0, raw_temperature}) -
                   $signed({1'b0, cal.c5, {bpc_pkg::REF_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d1 <= raw_pressure;
      s1_rv <= (raw_pressure != '0) && (raw_temperature != '0);
      s1_dt <= dt_next;
    end
  end

  // Stage 2: the four products of dT
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d1    <= s1_d1;
      s2_rv    <= s1_rv;
      s2_pt    <= s1_dt * $signed({1'b0, cal.c6});
      s2_poff  <= s1_dt * $signed({1'b0, cal.c4});
      s2_psens <= s1_dt * $signed({1'b0, cal.c3});
      s2_psq   <= s1_dt * s1_dt;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity
  assign a_c       = bpc_pkg::T_W'(s2_pt >>> bpc_pkg::T_SHIFT);
  assign off_base  = $signed({{(bpc_pkg::OFF_W - bpc_pkg::COEF_W - bpc_pkg::OFF_BASE_SHIFT){1'b0}},
                              cal.c2, {bpc_pkg::OFF_BASE_SHIFT{1'b0}}});
  assign sens_base = $signed({{(bpc_pkg::SENS_W - bpc_pkg::COEF_W - bpc_pkg::SENS_BASE_SHIFT){1'b0}},
                              cal.c1, {bpc_pkg::SENS_BASE_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (en3) begin
      dn_data.d1   <= s2_d1;
      dn_data.rv   <= s2_rv;
      dn_data.a    <= a_c;
      dn_data.temp <= a_c + bpc_pkg::T_W'(bpc_pkg::TEMP_REF);
      dn_data.b    <= a_c + bpc_pkg::T_W'(bpc_pkg::TEMP_REF - bpc_pkg::TEMP_COLD);
      dn_data.off  <= off_base + bpc_pkg::OFF_W'(s2_poff >>> bpc_pkg::OFF_SHIFT);
      dn_data.sens <= sens_base + bpc_pkg::SENS_W'(s2_psens >>> bpc_pkg::SENS_SHIFT);
      dn_data.t2   <= bpc_pkg::T_W'(s2_psq >>> bpc_pkg::T2_SHIFT);
    end
  end

endmodule

// ===== rtl/bpc_second_order.sv =====
`timescale 1ns / 1ps

module bpc_second_order (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  bpc_pkg::fo_t   up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bpc_pkg::so_t   dn_data
);

  logic v4;
  logic en4, en5;

  bpc_pkg::fo_t                       s4_fo;
  logic signed [bpc_pkg::TSQ_W-1:0]   s4_asq;
  logic signed [bpc_pkg::TSQ_W-1:0]   s4_bsq;
  logic                               s4_cold;    // below 20 C
  logic                               s4_frigid;  // below -15 C

  logic signed [bpc_pkg::TSQ_W-1:0]   five_asq;
  logic signed [bpc_pkg::TSQ_W-1:0]   seven_bsq;
  logic signed [bpc_pkg::TSQ_W-1:0]   eleven_bsq;
  logic signed [bpc_pkg::TSQ_W-1:0]   off2;
  logic signed [bpc_pkg::TSQ_W-1:0]   sens2;
  logic signed [bpc_pkg::T_W-1:0]     temp_f;
  logic signed [bpc_pkg::OFF_W-1:0]   off_f;
  logic signed [bpc_pkg::SENS_W-1:0]  sens_f;

  assign en5      = !dn_valid || dn_ready;
  assign en4      = !v4 || en5;
  assign up_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en4) v4 <= up_valid;
      if (en5) dn_valid <= v4;
    end
  end

  // Stage 4: squares of the temperature offsets
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_fo     <= up_data;
      s4_asq    <= up_data.a * up_data.a;
      s4_bsq    <= up_data.b * up_data.b;
      s4_cold   <= up_data.a[bpc_pkg::T_W-1];
      s4_frigid <= up_data.b[bpc_pkg::T_W-1];
    end
  end

  // Stage 5: second-order corrections by shift and add
  always_comb begin
    five_asq   = (s4_asq <<< 2) + s4_asq;
    seven_bsq  = (s4_bsq <<< 3) - s4_bsq;
    eleven_bsq = (s4_bsq <<< 3) + (s4_bsq <<< 1) + s4_bsq;
    off2       = five_asq >>> 1;
    sens2      = five_asq >>> 2;
    if (s4_frigid) begin
      off2  = off2 + seven_bsq;
      sens2 = sens2 + (eleven_bsq >>> 1);
    end
    temp_f = s4_fo.temp;
    off_f  = s4_fo.off;
    sens_f = s4_fo.sens;
    if (s4_cold) begin
      temp_f = s4_fo.temp - $signed(s4_fo.t2);
      off_f  = bpc_pkg::OFF_W'(s4_fo.off - off2);
      sens_f = bpc_pkg::SENS_W'(s4_fo.sens - sens2);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      dn_data.d1   <= s4_fo.d1;
      dn_data.rv   <= s4_fo.rv;
      dn_data.temp <= temp_f;
      dn_data.off  <= off_f;
      dn_data.sens <= sens_f;
    end
  end

endmodule

// ===== rtl/bpc_pressure.sv =====
`timescale 1ns / 1ps

module bpc_pressure (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cal_ok,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  bpc_pkg::so_t                            up_data,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output logic signed [bpc_pkg::TEMP_OUT_W-1:0]   temperature_centi,
  output logic [bpc_pkg::PRES_OUT_W-1:0]          pressure_centi_mbar,
  output logic                                    reading_valid,
  output logic                                    calibration_valid
);

  logic v6, v7;
  logic en6, en7, en8;

  logic [bpc_pkg::LO_W-1:0]           s6_lo;
  logic signed [bpc_pkg::HI_W-1:0]    s6_hi;
  logic signed [bpc_pkg::T_W-1:0]     s6_temp;
  logic signed [bpc_pkg::OFF_W-1:0]   s6_off;
  logic                               s6_rv;

  logic signed [bpc_pkg::FULL_W-1:0]  s7_full;
  logic signed [bpc_pkg::T_W-1:0]     s7_temp;
  logic signed [bpc_pkg::OFF_W-1:0]   s7_off;
  logic                               s7_rv;

  logic signed [bpc_pkg::FULL_W-1:0]  q_c;
  logic signed [bpc_pkg::FULL_W-1:0]  x_c;
  logic signed [bpc_pkg::FULL_W-1:0]  p_c;
  logic [bpc_pkg::PRES_OUT_W-1:0]     pres_sat;
  logic signed [bpc_pkg::TEMP_OUT_W-1:0] temp_sat;

  assign en8      = !dn_valid || dn_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign up_ready = en6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6       <= 1'b0;
      v7       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en6) v6 <= up_valid;
      if (en7) v7 <= v6;
      if (en8) dn_valid <= v7;
    end
  end

  // Stage 6: D1 * SENS as two partial products
  always_ff @(posedge clk) begin
    if (en6) begin
      s6_lo   <= up_data.d1 * up_data.sens[bpc_pkg::SPLIT_W-1:0];
      s6_hi   <= $signed({1'b0, up_data.d1}) *
                 $signed(up_data.sens[bpc_pkg::SENS_W-1:bpc_pkg::SPLIT_W]);
      s6_temp <= up_data.temp;
      s6_off  <= up_data.off;
      s6_rv   <= up_data.rv;
    end
  end

  // Stage 7: recombine the partial products
  always_ff @(posedge clk) begin
    if (en7) begin
      s7_full <= ($signed(bpc_pkg::FULL_W'(s6_hi)) <<< bpc_pkg::SPLIT_W) +
                 $signed(bpc_pkg::FULL_W'(s6_lo));
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_rv   <= s6_rv;
    end
  end

  // Stage 8: pressure, then clamp both outputs
  always_comb begin
    q_c = s7_full >>> bpc_pkg::MUL_SHIFT;
    x_c = q_c - bpc_pkg::FULL_W'(s7_off);
    p_c = x_c >>> bpc_pkg::P_SHIFT;
    if (p_c < 0) begin
      pres_sat = '0;
    end else if (p_c > bpc_pkg::FULL_W'(bpc_pkg::PRES_HIGH)) begin
      pres_sat = bpc_pkg::PRES_OUT_W'(bpc_pkg::PRES_HIGH);
    end else begin
      pres_sat = p_c[bpc_pkg::PRES_OUT_W-1:0];
    end
    if (s7_temp < bpc_pkg::T_W'(bpc_pkg::TEMP_LOW)) begin
      temp_sat = bpc_pkg::TEMP_OUT_W'(bpc_pkg::TEMP_LOW);
    end else if (s7_temp > bpc_pkg::T_W'(bpc_pkg::TEMP_HIGH)) begin
      temp_sat = bpc_pkg::TEMP_OUT_W'(bpc_pkg::TEMP_HIGH);
    end else begin
      temp_sat = s7_temp[bpc_pkg::TEMP_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      temperature_centi   <= temp_sat;
      pressure_centi_mbar <= pres_sat;
      reading_valid       <= s7_rv;
      calibration_valid   <= cal_ok;
    end
  end

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
`timescale 1ns / 1ps

// Second-order barometric compensation.
// sample: raw pressure D1 and raw temperature D2, one item per valid/ready
//   handshake. result: temperature in 0.01 C, pressure in 0.01 mbar (both
//   clamped to range), a flag for a nonzero reading and a flag for a sane
//   calibration set. Both values are always computed; the flags only report.
// cfg_we/cfg_index/cfg_data write the six 16-bit coefficients C1..C6
//   (index 0..5, others ignored). Write them only while no item is in flight.
// One item per cycle is sustained unless result.ready stalls the output. The
//   depth is set by the multiplier chain: dT products, squares of the
//   temperature offsets, and D1 * SENS split into two partial products that
//   are summed in the next stage.
// Every stage takes a new item whenever it is empty or drains, so bubbles
//   are squeezed out and sample.ready stays high while the result register
//   is empty. A stalled result holds its value and backs up the pipeline.
// Synchronous reset empties the pipeline and restores the coefficient
//   reset values; no clearing pass is needed.
module baro_pressure_temp_compensation (
  input  logic                           clk,
  input  logic                           rst,
  bpc_in_if.sink                         sample,
  bpc_out_if.source                      result,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]     cfg_data
);

  bpc_pkg::cal_t  cal;
  logic           cal_ok;

  logic           fo_valid, fo_ready;
  bpc_pkg::fo_t   fo_data;
  logic           so_valid, so_ready;
  bpc_pkg::so_t   so_data;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal),
    .cal_ok    (cal_ok)
  );

  // Stages 1-3
  bpc_first_order u_first (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .up_valid        (sample.valid),
    .up_ready        (sample.ready),
    .raw_pressure    (sample.raw_pressure),
    .raw_temperature (sample.raw_temperature),
    .dn_valid        (fo_valid),
    .dn_ready        (fo_ready),
    .dn_data         (fo_data)
  );

  // Stages 4-5
  bpc_second_order u_second (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fo_valid),
    .up_ready (fo_ready),
    .up_data  (fo_data),
    .dn_valid (so_valid),
    .dn_ready (so_ready),
    .dn_data  (so_data)
  );

  // Stages 6-8, stage 8 is the result register
  bpc_pressure u_pres (
    .clk                 (clk),
    .rst                 (rst),
    .cal_ok              (cal_ok),
    .up_valid            (so_valid),
    .up_ready            (so_ready),
    .up_data             (so_data),
    .dn_valid            (result.valid),
    .dn_ready            (result.ready),
    .temperature_centi   (result.temperature_centi),
    .pressure_centi_mbar (result.pressure_centi_mbar),
    .reading_valid       (result.reading_valid),
    .calibration_valid   (result.calibration_valid)
  );

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // An empty result register never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("input stalled with empty result register");

  // Temperature clamp holds on every delivered item
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      (result.temperature_centi >= bpc_pkg::TEMP_OUT_W'(bpc_pkg::TEMP_LOW)) &&
      (result.temperature_centi <= bpc_pkg::TEMP_OUT_W'(bpc_pkg::TEMP_HIGH)))
    else $error("temperature outside clamp range");

endmodule
